>>> hw/rtl/command_byte_parser_with_payload_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command byte parser
// Two property forms, each switched off as a whole by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef COMMAND_BYTE_PARSER_WITH_PAYLOAD_UNIT_ASSERT_SVH
`define COMMAND_BYTE_PARSER_WITH_PAYLOAD_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define CBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("parser assertion failed");

`define CBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("parser assertion failed");

`else

`define CBP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/cbp_pkg.sv
// ----------------------------------------------------------------------------
// Command byte parser package
// Widths, payload layout, event and register codes, and shared structs.
// ----------------------------------------------------------------------------
package cbp_pkg;

	localparam int PAYLOAD_LEN = 18;
	localparam int STORE_LEN   = PAYLOAD_LEN - 1;
	localparam int FIELD_BYTES = 17;
	localparam int CNT_W       = 5;
	localparam int IDX_W       = (STORE_LEN > 1) ? $clog2(STORE_LEN) : 1;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_GET     = 3'd1,
		EV_RESET   = 3'd2,
		EV_PING    = 3'd3,
		EV_SET_OK  = 3'd4,
		EV_SET_BAD = 3'd5,
		EV_START   = 3'd6,
		EV_STOP    = 3'd7
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT      = 3'd0,
		CFG_CODE_GET     = 3'd1,
		CFG_CODE_RESET   = 3'd2,
		CFG_CODE_SET     = 3'd3,
		CFG_CODE_START   = 3'd4,
		CFG_CODE_STOP    = 3'd5,
		CFG_CODE_PING    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [7:0]  code_get_gains;
		logic [7:0]  code_reset_integrators;
		logic [7:0]  code_set_gains;
		logic [7:0]  code_stream_start;
		logic [7:0]  code_stream_stop;
		logic [7:0]  code_ping;
	} cbp_cfg_t;

	typedef struct packed {
		event_t      event_res;
		logic        streaming_on;
		logic        receiving;
		logic [7:0]  gain_order;
		logic [31:0] kp_real_bits;
		logic [31:0] kp_imag_bits;
		logic [31:0] ki_real_bits;
		logic [31:0] ki_imag_bits;
	} cbp_res_t;

endpackage

>>> hw/rtl/cbp_if.sv
// ----------------------------------------------------------------------------
// Command byte parser channels
// Received byte channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface cbp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rx_byte;
	logic [31:0] now_ms;

	modport source (output valid, output rx_byte, output now_ms, input ready);
	modport sink (input valid, input rx_byte, input now_ms, output ready);
endinterface

interface cbp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic        streaming_on;
	logic        receiving;
	logic [7:0]  gain_order;
	logic [31:0] kp_real_bits;
	logic [31:0] kp_imag_bits;
	logic [31:0] ki_real_bits;
	logic [31:0] ki_imag_bits;

	modport source (output valid, output event_res, output streaming_on, output receiving,
		output gain_order, output kp_real_bits, output kp_imag_bits,
		output ki_real_bits, output ki_imag_bits, input ready);
	modport sink (input valid, input event_res, input streaming_on, input receiving,
		input gain_order, input kp_real_bits, input kp_imag_bits,
		input ki_real_bits, input ki_imag_bits, output ready);
endinterface

interface cbp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [cbp_pkg::CFG_IDX_W-1:0]     index;
	logic [cbp_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/cbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Timeout and the six command codes, written one per transfer.
// ----------------------------------------------------------------------------
module cbp_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	cbp_cfg_if.sink           cfg,
	output cbp_pkg::cbp_cfg_t regs
);
	import cbp_pkg::*;

	cbp_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.timeout_ms             <= 16'd50;
			regs_q.code_get_gains         <= 8'd71;
			regs_q.code_reset_integrators <= 8'd82;
			regs_q.code_set_gains         <= 8'd67;
			regs_q.code_stream_start      <= 8'd83;
			regs_q.code_stream_stop       <= 8'd88;
			regs_q.code_ping              <= 8'd80;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TIMEOUT:    regs_q.timeout_ms             <= cfg.data;
				CFG_CODE_GET:   regs_q.code_get_gains         <= cfg.data[7:0];
				CFG_CODE_RESET: regs_q.code_reset_integrators <= cfg.data[7:0];
				CFG_CODE_SET:   regs_q.code_set_gains         <= cfg.data[7:0];
				CFG_CODE_START: regs_q.code_stream_start      <= cfg.data[7:0];
				CFG_CODE_STOP:  regs_q.code_stream_stop       <= cfg.data[7:0];
				CFG_CODE_PING:  regs_q.code_ping              <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/cbp_core.sv
// ----------------------------------------------------------------------------
// Parser core
// Command decode, payload collection with timeout, checksum and field assembly.
// ----------------------------------------------------------------------------
module cbp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic [31:0]       now_ms,
	input  cbp_pkg::cbp_cfg_t regs,
	output cbp_pkg::cbp_res_t res
);
	import cbp_pkg::*;

	logic             collecting_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [31:0]      start_time_q;
	logic [7:0]       running_sum_q;
	logic             stream_enable_q;
	logic [7:0]       store_q [STORE_LEN];

	logic             collecting_d;
	logic [CNT_W-1:0] byte_count_d;
	logic [31:0]      start_time_d;
	logic [7:0]       running_sum_d;
	logic             stream_enable_d;

	logic [31:0]      elapsed;
	logic             timed_out;
	logic             in_payload;
	logic             last_byte;
	logic             store_wr;
	logic [7:0]       pay_bytes [FIELD_BYTES];

	for (genvar g = 0; g < FIELD_BYTES; g++) begin : g_field
		if (g < STORE_LEN) begin : g_stored
			assign pay_bytes[g] = store_q[g];
		end else begin : g_absent
			assign pay_bytes[g] = 8'd0;
		end
	end

	always_comb begin
		elapsed    = now_ms - start_time_q;
		timed_out  = collecting_q && (elapsed > {16'd0, regs.timeout_ms});
		in_payload = collecting_q && !timed_out;
		last_byte  = in_payload &&
			(({1'b0, byte_count_q} + (CNT_W+1)'(1)) >= (CNT_W+1)'(PAYLOAD_LEN));
		store_wr   = in_payload && !last_byte && (32'(byte_count_q) < 32'(STORE_LEN));

		collecting_d    = collecting_q && !timed_out;
		byte_count_d    = byte_count_q;
		start_time_d    = start_time_q;
		running_sum_d   = running_sum_q;
		stream_enable_d = stream_enable_q;

		res                = '0;
		res.event_res      = EV_NONE;

		if (in_payload) begin
			if (last_byte) begin
				res.event_res      = (running_sum_q == rx_byte) ? EV_SET_OK : EV_SET_BAD;
				res.gain_order     = pay_bytes[0];
				res.kp_real_bits   = {pay_bytes[4], pay_bytes[3], pay_bytes[2], pay_bytes[1]};
				res.kp_imag_bits   = {pay_bytes[8], pay_bytes[7], pay_bytes[6], pay_bytes[5]};
				res.ki_real_bits   = {pay_bytes[12], pay_bytes[11], pay_bytes[10], pay_bytes[9]};
				res.ki_imag_bits   = {pay_bytes[16], pay_bytes[15], pay_bytes[14], pay_bytes[13]};
				collecting_d       = 1'b0;
				byte_count_d       = '0;
			end else begin
				running_sum_d = running_sum_q + rx_byte;
				byte_count_d  = byte_count_q + CNT_W'(1);
			end
		end else begin
			if (rx_byte == regs.code_get_gains) begin
				res.event_res = EV_GET;
			end else if (rx_byte == regs.code_reset_integrators) begin
				res.event_res = EV_RESET;
			end else if (rx_byte == regs.code_set_gains) begin
				collecting_d  = 1'b1;
				byte_count_d  = '0;
				running_sum_d = 8'd0;
				start_time_d  = now_ms;
			end else if (rx_byte == regs.code_stream_start) begin
				stream_enable_d = 1'b1;
				res.event_res   = EV_START;
			end else if (rx_byte == regs.code_stream_stop) begin
				stream_enable_d = 1'b0;
				res.event_res   = EV_STOP;
			end else if (rx_byte == regs.code_ping) begin
				res.event_res = EV_PING;
			end
		end

		res.streaming_on = stream_enable_d;
		res.receiving    = collecting_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q    <= 1'b0;
			byte_count_q    <= '0;
			start_time_q    <= '0;
			running_sum_q   <= '0;
			stream_enable_q <= 1'b0;
		end else if (step) begin
			collecting_q    <= collecting_d;
			byte_count_q    <= byte_count_d;
			start_time_q    <= start_time_d;
			running_sum_q   <= running_sum_d;
			stream_enable_q <= stream_enable_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store_wr) begin
			store_q[byte_count_q[IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

>>> hw/rtl/command_byte_parser_with_payload_unit.sv
// ----------------------------------------------------------------------------
// Command byte parser with gain payload
// Decodes command bytes and collects a checksummed set-gains payload.
//
//   channel   role     transfer carries
//   in_ch     sink     rx_byte, now_ms
//   out_ch    source   event_res, streaming_on, receiving, payload fields
//   cfg       sink     index, data (always ready)
//
// One byte per cycle while the result is not stalled; each byte gives one result
// after its transfer, through an input register and then a result register.
// The decode and state update sit between those two registers.
// Reset clears the parser state and loads the default command codes and timeout.
// A stalled result holds both registers; input is still taken while the
// input register is empty.
// ----------------------------------------------------------------------------
`include "command_byte_parser_with_payload_unit_assert.svh"

module command_byte_parser_with_payload_unit (
	input  logic       clk,
	input  logic       arst_n,
	cbp_in_if.sink     in_ch,
	cbp_out_if.source  out_ch,
	cbp_cfg_if.sink    cfg
);
	import cbp_pkg::*;

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic [31:0] now_ms_s1;
	logic        out_valid_q;
	cbp_res_t    res_q;

	cbp_cfg_t    regs;
	cbp_res_t    res;
	logic        advance;
	logic        step;
	logic        in_fire;

	assign advance     = !out_valid_q || out_ch.ready;
	assign step        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire     = in_ch.valid && in_ch.ready;

	cbp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cbp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte_s1),
		.now_ms  (now_ms_s1),
		.regs    (regs),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rx_byte_s1 <= in_ch.rx_byte;
			now_ms_s1  <= in_ch.now_ms;
		end
		if (step) begin
			res_q <= res;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.event_res      = res_q.event_res;
	assign out_ch.streaming_on   = res_q.streaming_on;
	assign out_ch.receiving      = res_q.receiving;
	assign out_ch.gain_order     = res_q.gain_order;
	assign out_ch.kp_real_bits   = res_q.kp_real_bits;
	assign out_ch.kp_imag_bits   = res_q.kp_imag_bits;
	assign out_ch.ki_real_bits   = res_q.ki_real_bits;
	assign out_ch.ki_imag_bits   = res_q.ki_imag_bits;

	`CBP_ASSERT_NEXT(a_accept_loads_s1, clk, arst_n, in_fire, valid_s1)
	`CBP_ASSERT_SAME(a_full_and_stalled_blocks, clk, arst_n,
		valid_s1 && out_valid_q && !out_ch.ready, !in_ch.ready)
	`CBP_ASSERT_SAME(a_set_ends_collection, clk, arst_n,
		out_valid_q && (res_q.event_res == EV_SET_OK || res_q.event_res == EV_SET_BAD),
		!res_q.receiving)
	`CBP_ASSERT_SAME(a_fields_zero_without_set, clk, arst_n,
		out_valid_q && res_q.event_res != EV_SET_OK && res_q.event_res != EV_SET_BAD,
		res_q.gain_order == 8'd0 && res_q.kp_real_bits == 32'd0 &&
		res_q.ki_imag_bits == 32'd0)

endmodule
